FILE: src/calculator_token_scanner_assert.svh
// ----------------------------------------------------------------------------
// calculator_token_scanner_assert.svh
// Assertion macros for the calculator token scanner.
// ----------------------------------------------------------------------------
`ifndef CALCULATOR_TOKEN_SCANNER_ASSERT_SVH
`define CALCULATOR_TOKEN_SCANNER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define CTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scanner assertion failed");
// next-cycle implication
`define CTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scanner assertion failed");
`else
`define CTS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CTS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/cts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types and codes of the calculator token scanner.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int MAX_IMAGE_CHARS_DEF = 8;
  localparam int IMAGE_BYTES         = 8;
  localparam int FIFO_DEPTH          = 4;

  localparam logic [3:0] K_READ    = 4'd0;
  localparam logic [3:0] K_WRITE   = 4'd1;
  localparam logic [3:0] K_ID      = 4'd2;
  localparam logic [3:0] K_LITERAL = 4'd3;
  localparam logic [3:0] K_BECOMES = 4'd4;
  localparam logic [3:0] K_ADD     = 4'd5;
  localparam logic [3:0] K_SUB     = 4'd6;
  localparam logic [3:0] K_MUL     = 4'd7;
  localparam logic [3:0] K_DIV     = 4'd8;
  localparam logic [3:0] K_LPAREN  = 4'd9;
  localparam logic [3:0] K_RPAREN  = 4'd10;
  localparam logic [3:0] K_EOF     = 4'd11;
  localparam logic [3:0] K_SEMI    = 4'd12;
  localparam logic [3:0] K_ERROR   = 4'd13;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_COMMENT  = 2'd1;
  localparam logic [1:0] ERR_COLON    = 2'd2;
  localparam logic [1:0] ERR_BAD_CHAR = 2'd3;

  typedef struct packed {
    logic [3:0]  kind;
    logic [1:0]  err;
    logic [15:0] line;
    logic [63:0] image;
    logic [3:0]  len;
    logic        trunc;
    logic [7:0]  bad;
    logic        last;
  } res_t;

  function automatic res_t make_res(logic [3:0] kind, logic [1:0] err, logic [15:0] line,
                                    logic [63:0] image, logic [3:0] len, logic trunc,
                                    logic [7:0] bad);
    res_t r;
    r.kind  = kind;
    r.err   = err;
    r.line  = line;
    r.image = image;
    r.len   = len;
    r.trunc = trunc;
    r.bad   = bad;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

FILE: src/cts_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_core
// Scanner state and per-character next-state logic; up to two items out.
// ----------------------------------------------------------------------------
module cts_core #(
  parameter int MAX_IMAGE_CHARS = cts_pkg::MAX_IMAGE_CHARS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  logic [7:0]     char_code_i,
  input  logic           end_of_input_i,
  output cts_pkg::res_t  res0_o,
  output cts_pkg::res_t  res1_o,
  output logic [1:0]     res_n_o
);

  localparam logic [3:0] M_START      = 4'd0;
  localparam logic [3:0] M_SLASH      = 4'd1;
  localparam logic [3:0] M_BLOCK      = 4'd2;
  localparam logic [3:0] M_BLOCK_STAR = 4'd3;
  localparam logic [3:0] M_LINE       = 4'd4;
  localparam logic [3:0] M_NUMBER     = 4'd5;
  localparam logic [3:0] M_IDENT      = 4'd6;
  localparam logic [3:0] M_COLON      = 4'd7;
  localparam logic [3:0] M_DONE       = 4'd8;
  localparam logic [3:0] M_HALT       = 4'd9;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  localparam logic [63:0] IMG_READ  = 64'h0000_0000_6461_6572;
  localparam logic [63:0] IMG_WRITE = 64'h0000_0065_7469_7277;
  localparam logic [3:0]  LEN_READ  = 4'd4;
  localparam logic [3:0]  LEN_WRITE = 4'd5;
  localparam logic [3:0]  MAX_LEN   = 4'(MAX_IMAGE_CHARS);

  logic [3:0]  mode_q, mode_d;
  logic [63:0] buf_q, buf_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        ovf_q, ovf_d;
  logic [15:0] line_q, line_d;

  logic        is_digit, is_alpha, is_space;
  logic [7:0]  c;
  logic        eoi;

  logic [3:0]    f_mode;
  logic          f_emit;
  cts_pkg::res_t f_res;
  logic [63:0]   f_buf;
  logic [3:0]    f_cnt;
  logic          f_bump;

  logic [63:0]   app_buf;
  logic [3:0]    app_cnt;
  logic          app_ovf;
  logic [3:0]    word_kind;
  logic          bump;
  cts_pkg::res_t res0, res1;
  logic [1:0]    res_n;

  assign c        = char_code_i;
  assign eoi      = end_of_input_i;
  assign is_digit = (c >= 8'h30) && (c <= 8'h39);
  assign is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  assign is_space = c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

  // fresh scan of the current character from between tokens
  always_comb begin
    f_mode = M_START;
    f_emit = 1'b0;
    f_res  = cts_pkg::make_res(cts_pkg::K_EOF, cts_pkg::ERR_NONE, line_q, '0, '0, 1'b0, '0);
    f_buf  = '0;
    f_cnt  = '0;
    f_bump = 1'b0;
    if (eoi) begin
      f_emit = 1'b1;
      f_mode = M_DONE;
    end else if (is_space) begin
      f_bump = (c == CH_NL);
    end else if (c == CH_SLASH) begin
      f_mode = M_SLASH;
    end else if (is_digit || is_alpha) begin
      f_buf  = {56'd0, c};
      f_cnt  = 4'd1;
      f_mode = is_digit ? M_NUMBER : M_IDENT;
    end else begin
      f_emit = 1'b1;
      case (c)
        CH_COLON: begin
          f_emit = 1'b0;
          f_mode = M_COLON;
        end
        CH_PLUS:  f_res.kind = cts_pkg::K_ADD;
        CH_MINUS: f_res.kind = cts_pkg::K_SUB;
        CH_STAR:  f_res.kind = cts_pkg::K_MUL;
        CH_LPAR:  f_res.kind = cts_pkg::K_LPAREN;
        CH_RPAR:  f_res.kind = cts_pkg::K_RPAREN;
        CH_SEMI:  f_res.kind = cts_pkg::K_SEMI;
        default: begin
          f_res.kind = cts_pkg::K_ERROR;
          f_res.err  = cts_pkg::ERR_BAD_CHAR;
          f_res.bad  = c;
          f_mode     = M_HALT;
        end
      endcase
    end
  end

  // append to the image
  always_comb begin
    app_buf = buf_q;
    for (int i = 0; i < cts_pkg::IMAGE_BYTES; i++) begin
      if ((i < MAX_IMAGE_CHARS) && (cnt_q == 4'(i))) begin
        app_buf[8*i +: 8] = c;
      end
    end
    app_cnt = (cnt_q < MAX_LEN) ? cnt_q + 4'd1 : cnt_q;
    app_ovf = ovf_q | (cnt_q >= MAX_LEN);
  end

  always_comb begin
    word_kind = cts_pkg::K_ID;
    if (!ovf_q && (cnt_q == LEN_READ) && (buf_q == IMG_READ)) begin
      word_kind = cts_pkg::K_READ;
    end else if (!ovf_q && (cnt_q == LEN_WRITE) && (buf_q == IMG_WRITE)) begin
      word_kind = cts_pkg::K_WRITE;
    end
  end

  always_comb begin
    mode_d = mode_q;
    buf_d  = buf_q;
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    bump   = 1'b0;
    res0   = f_res;
    res1   = f_res;
    res_n  = 2'd0;
    case (mode_q)
      M_START: begin
        mode_d = f_mode;
        buf_d  = f_buf;
        cnt_d  = f_cnt;
        ovf_d  = 1'b0;
        bump   = f_bump;
        res_n  = {1'b0, f_emit};
      end
      M_SLASH: begin
        if (!eoi && (c == CH_STAR)) begin
          mode_d = M_BLOCK;
        end else if (!eoi && (c == CH_SLASH)) begin
          mode_d = M_LINE;
        end else begin
          res0   = cts_pkg::make_res(cts_pkg::K_DIV, cts_pkg::ERR_NONE, line_q,
                                     '0, '0, 1'b0, '0);
          mode_d = f_mode;
          buf_d  = f_buf;
          cnt_d  = f_cnt;
          ovf_d  = 1'b0;
          bump   = f_bump;
          res_n  = f_emit ? 2'd2 : 2'd1;
        end
      end
      M_BLOCK, M_BLOCK_STAR: begin
        if (eoi) begin
          res0   = cts_pkg::make_res(cts_pkg::K_ERROR, cts_pkg::ERR_COMMENT, line_q,
                                     '0, '0, 1'b0, '0);
          res_n  = 2'd1;
          mode_d = M_HALT;
        end else if ((c == CH_SLASH) && (mode_q == M_BLOCK_STAR)) begin
          mode_d = M_START;
        end else begin
          bump   = (c == CH_NL);
          mode_d = (c == CH_STAR) ? M_BLOCK_STAR : M_BLOCK;
        end
      end
      M_LINE: begin
        if (eoi) begin
          mode_d = f_mode;
          res_n  = {1'b0, f_emit};
        end else if (c == CH_NL) begin
          bump   = 1'b1;
          mode_d = M_START;
        end
      end
      M_NUMBER, M_IDENT: begin
        if (!eoi && (is_digit || (is_alpha && (mode_q == M_IDENT)))) begin
          buf_d = app_buf;
          cnt_d = app_cnt;
          ovf_d = app_ovf;
        end else begin
          res0   = cts_pkg::make_res((mode_q == M_NUMBER) ? cts_pkg::K_LITERAL : word_kind,
                                     cts_pkg::ERR_NONE, line_q, buf_q, cnt_q, ovf_q, '0);
          mode_d = f_mode;
          buf_d  = f_buf;
          cnt_d  = f_cnt;
          ovf_d  = 1'b0;
          bump   = f_bump;
          res_n  = f_emit ? 2'd2 : 2'd1;
        end
      end
      M_COLON: begin
        res_n = 2'd1;
        if (!eoi && (c == CH_EQ)) begin
          res0   = cts_pkg::make_res(cts_pkg::K_BECOMES, cts_pkg::ERR_NONE, line_q,
                                     '0, '0, 1'b0, '0);
          mode_d = M_START;
        end else begin
          res0   = cts_pkg::make_res(cts_pkg::K_ERROR, cts_pkg::ERR_COLON, line_q,
                                     '0, '0, 1'b0, CH_COLON);
          mode_d = M_HALT;
        end
      end
      M_DONE: begin
        res0  = cts_pkg::make_res(cts_pkg::K_EOF, cts_pkg::ERR_NONE, line_q,
                                  '0, '0, 1'b0, '0);
        res_n = 2'd1;
      end
      default: begin
        mode_d = M_HALT;
      end
    endcase
    res0.last = (res_n == 2'd1);
    res1.last = 1'b1;
    line_d    = (bump && (line_q != 16'hFFFF)) ? line_q + 16'd1 : line_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_START;
      buf_q  <= '0;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      line_q <= 16'd1;
    end else if (fire_i) begin
      mode_q <= mode_d;
      buf_q  <= buf_d;
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
      line_q <= line_d;
    end
  end

  assign res0_o  = res0;
  assign res1_o  = res1;
  assign res_n_o = res_n;

endmodule

FILE: src/cts_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_fifo
// Result queue: takes up to two items a cycle, gives one.
// ----------------------------------------------------------------------------
module cts_fifo (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic [1:0]                               push_n_i,
  input  cts_pkg::res_t                            push0_i,
  input  cts_pkg::res_t                            push1_i,
  input  logic                                     pop_i,
  output cts_pkg::res_t                            head_o,
  output logic [$clog2(cts_pkg::FIFO_DEPTH+1)-1:0] count_o
);

  localparam int PW = $clog2(cts_pkg::FIFO_DEPTH);
  localparam int CW = $clog2(cts_pkg::FIFO_DEPTH + 1);

  cts_pkg::res_t mem_q [cts_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] count_q;
  logic [PW-1:0] wr_next;

  assign wr_next = wr_q + PW'(1);

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_next] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + PW'(push_n_i);
      rd_q    <= rd_q + PW'(pop_i);
      count_q <= count_q + CW'(push_n_i) - CW'(pop_i);
    end
  end

  assign head_o  = mem_q[rd_q];
  assign count_o = count_q;

endmodule

FILE: src/calculator_token_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calculator_token_scanner
// Streaming lexical scanner for the calculator language.
//
//   channel  direction  handshake                payload
//   in       sink       in_valid_i / in_stall_o  char_code_i, end_of_input_i
//   out      source     out_valid_o/ out_stall_i token_kind_o ... last_of_run_o
//
// A character is taken each unstalled cycle; its tokens (zero, one or two) enter
// a four-entry result queue at the same edge and leave one per unstalled cycle.
// The input stalls while fewer than two queue entries are free.
// Reset returns the scanner to between tokens with the line count at one.
// After an error item the scanner takes characters but gives nothing more.
// ----------------------------------------------------------------------------
`include "calculator_token_scanner_assert.svh"

module calculator_token_scanner #(
  parameter int MAX_IMAGE_CHARS = cts_pkg::MAX_IMAGE_CHARS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  token_kind_o,
  output logic [1:0]  error_code_o,
  output logic [15:0] line_number_o,
  output logic [63:0] lexeme_o,
  output logic [3:0]  image_length_o,
  output logic        image_truncated_o,
  output logic [7:0]  offending_char_o,
  output logic        last_of_run_o
);

  localparam int CW = $clog2(cts_pkg::FIFO_DEPTH + 1);

  logic          in_fire, out_fire;
  cts_pkg::res_t res0, res1, head;
  logic [1:0]    res_n, push_n;
  logic [CW-1:0] count;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;
  assign push_n   = in_fire ? res_n : 2'd0;

  cts_core #(
    .MAX_IMAGE_CHARS(MAX_IMAGE_CHARS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (in_fire),
    .char_code_i    (char_code_i),
    .end_of_input_i (end_of_input_i),
    .res0_o         (res0),
    .res1_o         (res1),
    .res_n_o        (res_n)
  );

  cts_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .push0_i  (res0),
    .push1_i  (res1),
    .pop_i    (out_fire),
    .head_o   (head),
    .count_o  (count)
  );

  assign in_stall_o        = count > CW'(cts_pkg::FIFO_DEPTH - 2);
  assign out_valid_o       = count != '0;
  assign token_kind_o      = head.kind;
  assign error_code_o      = head.err;
  assign line_number_o     = head.line;
  assign lexeme_o          = head.image;
  assign image_length_o    = head.len;
  assign image_truncated_o = head.trunc;
  assign offending_char_o  = head.bad;
  assign last_of_run_o     = head.last;

  `CTS_ASSERT_IMP(a_queue_bound, clk_i, rst_ni, 1'b1, count <= CW'(cts_pkg::FIFO_DEPTH))
  `CTS_ASSERT_IMP(a_stall_room, clk_i, rst_ni, !in_stall_o,
                  count <= CW'(cts_pkg::FIFO_DEPTH - 2))
  `CTS_ASSERT_NXT(a_pair_follows, clk_i, rst_ni, out_fire && !last_of_run_o, out_valid_o)
  `CTS_ASSERT_NXT(a_error_final, clk_i, rst_ni,
                  out_fire && (token_kind_o == cts_pkg::K_ERROR), !out_valid_o)

endmodule

FILE: sim/calculator_token_scanner_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calculator_token_scanner_test
// Self-checking bench for the calculator token scanner. Character items are
// sent over the valid/stall input channel while a scoreboard predicts the
// tokens each one yields. Tokens taken from the output channel are checked
// field by field in order. A short directed stream is followed by random
// well-formed source text, a few newlines inside and outside comments, and
// one randomly chosen ending: end of input, or one of the lexical errors,
// each followed by a few further items.
// ----------------------------------------------------------------------------
module calculator_token_scanner_test;

  localparam int IMAGE_MAX    = cts_pkg::MAX_IMAGE_CHARS_DEF;
  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT  = 50000;
  localparam logic [7:0] NEWLINE = 8'h0A;
  localparam logic [7:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

  typedef enum logic [3:0] {
    SCAN_START, SCAN_SLASH, SCAN_BLOCK, SCAN_BLOCK_STAR, SCAN_LINE,
    SCAN_NUMBER, SCAN_IDENT, SCAN_COLON, SCAN_DONE, SCAN_HALT
  } scan_mode_e;

  class token_scoreboard;
    cts_pkg::res_t expected_tokens[$];
    cts_pkg::res_t burst[$];
    scan_mode_e    mode;
    logic [63:0]   image;
    int unsigned   image_len;
    bit            image_long;
    int unsigned   line_count;
    int            mismatches;
    int            token_no;

    function new();
      mode       = SCAN_START;
      image      = '0;
      image_len  = 0;
      image_long = 1'b0;
      line_count = 1;
      mismatches = 0;
      token_no   = 0;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function logic [63:0] word_image(string s);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < s.len(); i++) v[8*i +: 8] = s[i];
      return v;
    endfunction

    function void put_token(logic [3:0] kind, logic [1:0] err, logic [63:0] img,
                            logic [3:0] len, logic trunc, logic [7:0] bad);
      cts_pkg::res_t r;
      r.kind  = kind;
      r.err   = err;
      r.line  = line_count[15:0];
      r.image = img;
      r.len   = len;
      r.trunc = trunc;
      r.bad   = bad;
      r.last  = 1'b0;
      burst.push_back(r);
    endfunction

    function void put_plain(logic [3:0] kind);
      put_token(kind, cts_pkg::ERR_NONE, '0, '0, 1'b0, '0);
    endfunction

    function void put_error(logic [1:0] err, logic [7:0] bad);
      put_token(cts_pkg::K_ERROR, err, '0, '0, 1'b0, bad);
      mode = SCAN_HALT;
    endfunction

    function void clear_image();
      image      = '0;
      image_len  = 0;
      image_long = 1'b0;
    endfunction

    function void add_char(logic [7:0] c);
      if (image_len < IMAGE_MAX) begin
        image[8*image_len +: 8] = c;
        image_len++;
      end else begin
        image_long = 1'b1;
      end
    endfunction

    function void next_line();
      if (line_count < 16'hFFFF) line_count++;
    endfunction

    function void emit_image(logic [3:0] kind);
      put_token(kind, cts_pkg::ERR_NONE, image, 4'(image_len), image_long, '0);
      clear_image();
    endfunction

    function void emit_word();
      logic [3:0] kind;
      kind = cts_pkg::K_ID;
      if (!image_long) begin
        if (image_len == 4 && image == word_image("read")) kind = cts_pkg::K_READ;
        else if (image_len == 5 && image == word_image("write")) kind = cts_pkg::K_WRITE;
      end
      emit_image(kind);
    endfunction

    function void scan_fresh(logic [7:0] c, bit eoi);
      if (eoi) begin
        put_plain(cts_pkg::K_EOF);
        mode = SCAN_DONE;
        return;
      end
      mode = SCAN_START;
      if (is_blank(c)) begin
        if (c == NEWLINE) next_line();
      end else if (c == "/") begin
        mode = SCAN_SLASH;
      end else if (is_digit(c)) begin
        clear_image();
        add_char(c);
        mode = SCAN_NUMBER;
      end else if (is_alpha(c)) begin
        clear_image();
        add_char(c);
        mode = SCAN_IDENT;
      end else begin
        case (c)
          ":": mode = SCAN_COLON;
          "+": put_plain(cts_pkg::K_ADD);
          "-": put_plain(cts_pkg::K_SUB);
          "*": put_plain(cts_pkg::K_MUL);
          "(": put_plain(cts_pkg::K_LPAREN);
          ")": put_plain(cts_pkg::K_RPAREN);
          ";": put_plain(cts_pkg::K_SEMI);
          default: put_error(cts_pkg::ERR_BAD_CHAR, c);
        endcase
      end
    endfunction

    function void note_char(logic [7:0] c, bit eoi);
      cts_pkg::res_t r;
      burst.delete();
      case (mode)
        SCAN_START: scan_fresh(c, eoi);
        SCAN_SLASH: begin
          if (!eoi && c == "*") mode = SCAN_BLOCK;
          else if (!eoi && c == "/") mode = SCAN_LINE;
          else begin
            put_plain(cts_pkg::K_DIV);
            scan_fresh(c, eoi);
          end
        end
        SCAN_BLOCK, SCAN_BLOCK_STAR: begin
          if (eoi) put_error(cts_pkg::ERR_COMMENT, '0);
          else if (c == "/" && mode == SCAN_BLOCK_STAR) mode = SCAN_START;
          else begin
            if (c == NEWLINE) next_line();
            mode = (c == "*") ? SCAN_BLOCK_STAR : SCAN_BLOCK;
          end
        end
        SCAN_LINE: begin
          if (eoi) scan_fresh(c, eoi);
          else if (c == NEWLINE) begin
            next_line();
            mode = SCAN_START;
          end
        end
        SCAN_NUMBER: begin
          if (!eoi && is_digit(c)) add_char(c);
          else begin
            emit_image(cts_pkg::K_LITERAL);
            scan_fresh(c, eoi);
          end
        end
        SCAN_IDENT: begin
          if (!eoi && (is_alpha(c) || is_digit(c))) add_char(c);
          else begin
            emit_word();
            scan_fresh(c, eoi);
          end
        end
        SCAN_COLON: begin
          if (!eoi && c == "=") begin
            put_plain(cts_pkg::K_BECOMES);
            mode = SCAN_START;
          end else begin
            put_error(cts_pkg::ERR_COLON, ":");
          end
        end
        SCAN_DONE: put_plain(cts_pkg::K_EOF);
        default: mode = SCAN_HALT;
      endcase
      for (int i = 0; i < burst.size(); i++) begin
        r      = burst[i];
        r.last = (i == burst.size() - 1);
        expected_tokens.push_back(r);
      end
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch: %s", msg);
    endtask

    task check_token(cts_pkg::res_t got);
      cts_pkg::res_t want;
      string         diff;
      token_no++;
      if (expected_tokens.size() == 0) begin
        report($sformatf("token %0d of kind %0d not expected", token_no, got.kind));
        return;
      end
      want = expected_tokens.pop_front();
      diff = "";
      if (got.kind !== want.kind) diff = {diff, " kind"};
      if (got.err !== want.err) diff = {diff, " error_code"};
      if (got.line !== want.line) diff = {diff, " line_number"};
      if (got.image !== want.image) diff = {diff, " lexeme"};
      if (got.len !== want.len) diff = {diff, " image_length"};
      if (got.trunc !== want.trunc) diff = {diff, " image_truncated"};
      if (got.bad !== want.bad) diff = {diff, " offending_char"};
      if (got.last !== want.last) diff = {diff, " last_of_run"};
      if (diff != "")
        report($sformatf("token %0d:%s got %h want %h", token_no, diff, got, want));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  char_code;
  logic        end_mark;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  token_kind;
  logic [1:0]  error_code;
  logic [15:0] line_number;
  logic [63:0] lexeme;
  logic [3:0]  image_length;
  logic        image_truncated;
  logic [7:0]  offending_char;
  logic        last_of_run;

  bit quiet = 1'b0;
  int scan_items = 0;
  int cycles = 0;
  token_scoreboard tokens = new();

  calculator_token_scanner #(
    .MAX_IMAGE_CHARS(IMAGE_MAX)
  ) u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .char_code_i      (char_code),
    .end_of_input_i   (end_mark),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .token_kind_o     (token_kind),
    .error_code_o     (error_code),
    .line_number_o    (line_number),
    .lexeme_o         (lexeme),
    .image_length_o   (image_length),
    .image_truncated_o(image_truncated),
    .offending_char_o (offending_char),
    .last_of_run_o    (last_of_run)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_letter();
    int r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  task automatic send_char(logic [7:0] c, bit eoi);
    int gap;
    gap = draw_gap();
    repeat (gap) @(negedge clk) in_valid <= 1'b0;
    @(negedge clk);
    in_valid  <= 1'b1;
    char_code <= c;
    end_mark  <= eoi;
    do @(posedge clk); while (in_stall);
    tokens.note_char(c, eoi);
    scan_items++;
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_char(s[i], 1'b0);
  endtask

  task automatic send_word(bit digits_only);
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(IMAGE_MAX - 1, IMAGE_MAX + 4)
                                    : $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      if (digits_only) send_char(rand_digit(), 1'b0);
      else if (i == 0 || $urandom_range(0, 3) != 0) send_char(rand_letter(), 1'b0);
      else send_char(rand_digit(), 1'b0);
    end
  endtask

  task automatic send_comment(bit block);
    int         n;
    logic [7:0] c;
    logic [7:0] prev;
    send_text(block ? "/*" : "//");
    n    = $urandom_range(0, 6);
    prev = 8'h00;
    repeat (n) begin
      c = 8'($urandom_range(0, 255));
      if (block && prev == "*" && c == "/") c = "x";
      if (!block && c == NEWLINE) c = 8'h00;
      send_char(c, 1'b0);
      prev = c;
    end
    if (block) send_text("*/");
    else send_char(NEWLINE, 1'b0);
  endtask

  initial begin
    int         n;
    logic [7:0] c;
    string      ops;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    char_code = 8'h00;
    end_mark  = 1'b0;
    ops       = "+-*/();";
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // each token kind but end of input and error, truncated image, a slash that does not end a comment
    send_text("read x:=7/(ab-write)*9+c;");
    send_text("abcdefghij/*/");
    send_char(NEWLINE, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_text("**/");
    foreach (BLANKS[i]) send_char(BLANKS[i], 1'b0);

    scan_items = 0;
    while (scan_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 15) == 0) quiet = !quiet;
      case ($urandom_range(0, 11))
        0: send_text($urandom_range(0, 1) ? "read" : "write");
        1, 2: send_word(1'b0);
        3: send_word(1'b1);
        4: send_text(":=");
        5, 6: begin
          c = ops[$urandom_range(0, ops.len() - 1)];
          send_char(c, 1'b0);
          if (c == "/") send_char(BLANKS[$urandom_range(0, 5)], 1'b0);
        end
        7, 8: begin
          n = $urandom_range(1, 3);
          repeat (n) send_char(BLANKS[$urandom_range(0, 5)], 1'b0);
        end
        9: send_comment(1'b0);
        10: send_comment(1'b1);
        default: begin
          send_char("/", 1'b0);
          send_word(1'($urandom_range(0, 1)));
        end
      endcase
    end

    quiet = 1'b0;
    send_text("x;");
    send_char(NEWLINE, 1'b0);
    send_text("/*");
    send_char(NEWLINE, 1'b0);
    send_text("*/y ");

    case ($urandom_range(0, 7))
      0: send_char(8'($urandom_range(0, 255)), 1'b1);
      1: begin
        send_word(1'b0);
        send_char(8'($urandom_range(0, 255)), 1'b1);
      end
      2: begin
        send_word(1'b1);
        send_char(8'($urandom_range(0, 255)), 1'b1);
      end
      3: begin
        send_char(":", 1'b0);
        c = 8'($urandom_range(0, 255));
        if (c == "=") c = "!";
        send_char(c, 1'($urandom_range(0, 1)));
      end
      4: begin
        send_text("/*a*");
        send_char(8'($urandom_range(0, 255)), 1'b1);
      end
      5: begin
        if ($urandom_range(0, 1)) begin
          c = 8'($urandom_range(128, 255));
        end else begin
          do c = 8'($urandom_range(0, 127));
          while (tokens.is_digit(c) || tokens.is_alpha(c) || tokens.is_blank(c) ||
                 c inside {"/", ":", "+", "-", "*", "(", ")", ";"});
        end
        send_char(c, 1'b0);
      end
      6: begin
        send_char("/", 1'b0);
        send_char(8'($urandom_range(0, 255)), 1'b1);
      end
      default: begin
        send_text("//ab");
        send_char(8'($urandom_range(0, 255)), 1'b1);
      end
    endcase
    repeat (6) send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    @(negedge clk) in_valid <= 1'b0;

    while (tokens.expected_tokens.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (tokens.expected_tokens.size() != 0)
      tokens.report($sformatf("%0d tokens never arrived", tokens.expected_tokens.size()));
    if (tokens.mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    int            gap;
    cts_pkg::res_t got;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = draw_gap();
      repeat (gap) @(negedge clk) out_stall <= 1'b1;
      @(negedge clk) out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got.kind  = token_kind;
      got.err   = error_code;
      got.line  = line_number;
      got.image = lexeme;
      got.len   = image_length;
      got.trunc = image_truncated;
      got.bad   = offending_char;
      got.last  = last_of_run;
      tokens.check_token(got);
    end
  end

endmodule
